>>> hdl/spq_pkg.sv
// Package with the shared widths, codes and types of the stable priority queue.
`default_nettype none

package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int PRIO_W   = 16;
  localparam int TAG_W    = 16;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_PUSHED = 2'd0,
    ST_POPPED = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  // Contents of one slot of the chain.
  typedef struct packed {
    logic              valid;
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  // Command broadcast to every cell in a cycle.
  typedef struct packed {
    logic              push;
    logic              pop;
    logic [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]  tag;
  } cmd_t;

endpackage

`default_nettype wire

>>> hdl/spq_if.sv
// Handshake channel interfaces for the input and result words of the queue.
`default_nettype none

interface spq_in_if import spq_pkg::*; ;
  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic signed [PRIO_W-1:0] priority_req;
  logic [TAG_W-1:0]         tag;

  modport source (output valid, output operation, output priority_req, output tag,
                  input ready);
  modport sink   (input valid, input operation, input priority_req, input tag,
                  output ready);
endinterface

interface spq_out_if import spq_pkg::*; ;
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic [TAG_W-1:0]         out_tag;
  logic signed [PRIO_W-1:0] out_priority;

  modport source (output valid, output status, output out_tag, output out_priority,
                  input ready);
  modport sink   (input valid, input status, input out_tag, input out_priority,
                  output ready);
endinterface

`default_nettype wire

>>> hdl/stable_priority_queue.sv
// Top level of the stable priority queue: a chain of slot cells and a result register.
`default_nettype none

// A result word is registered and appears in the cycle after its input word is accepted.
// Throughput: one word per cycle while the result register is free or its word
// leaves; every cell compares its priority with the incoming one in parallel.
// Reset clears every slot's valid bit and the result valid flag; slot contents
// and result fields are left as they are and are never read before they are written.
module stable_priority_queue import spq_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  spq_in_if.sink   in_i,
  spq_out_if.source out_o
);

  // Broadcast command and the chain wiring between neighboring cells.
  cmd_t                  cmd;
  entry_t [CAPACITY-1:0] ent;
  logic   [CAPACITY-1:0] ge;
  logic   [CAPACITY-1:0] vld;

  logic in_acc;
  logic is_pop;
  logic is_full;
  logic is_empty;

  // Result register. A new word is taken whenever the register is free or its
  // word leaves in the same cycle, so the chain never waits on an idle sink.
  logic              out_valid_q;
  status_e           status_q, status_d;
  logic [TAG_W-1:0]  tag_q, tag_d;
  logic [PRIO_W-1:0] prio_q, prio_d;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;
  assign is_pop     = (in_i.operation == OP_POP);
  assign is_empty   = !ent[0].valid;
  assign is_full    = ent[CAPACITY-1].valid;

  // A pop on an empty queue and a push on a full one leave the chain alone.
  assign cmd.push = in_acc && !is_pop && !is_full;
  assign cmd.pop  = in_acc && is_pop && !is_empty;
  assign cmd.prio = in_i.priority_req;
  assign cmd.tag  = in_i.tag;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t prev_ent;
    entry_t next_ent;
    logic   prev_ge;

    if (i == 0) begin : g_head
      assign prev_ent = '0;
      assign prev_ge  = 1'b1;
    end else begin : g_body
      assign prev_ent = ent[i-1];
      assign prev_ge  = ge[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_ent = '0;
    end else begin : g_link
      assign next_ent = ent[i+1];
    end

    spq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd),
      .prev_i    (prev_ent),
      .prev_ge_i (prev_ge),
      .next_i    (next_ent),
      .ent_o     (ent[i]),
      .ge_o      (ge[i])
    );

    assign vld[i] = ent[i].valid;
  end

  // The head slot always holds the next entry to leave.
  always_comb begin
    status_d = ST_PUSHED;
    tag_d    = '0;
    prio_d   = '0;
    if (is_pop) begin
      if (is_empty) begin
        status_d = ST_EMPTY;
      end else begin
        status_d = ST_POPPED;
        tag_d    = ent[0].tag;
        prio_d   = ent[0].prio;
      end
    end else if (is_full) begin
      status_d = ST_FULL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      status_q <= status_d;
      tag_q    <= tag_d;
      prio_q   <= prio_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = status_q;
  assign out_o.out_tag      = tag_q;
  assign out_o.out_priority = prio_q;

  // The occupied slots always form a prefix starting at the head.
  a_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld & (vld + CAPACITY'(1))) == '0)
    else $error("occupied slots do not form a prefix");

  // A successful pop returns the entry that sat at the head.
  a_pop_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pop |=> (out_o.valid && out_o.status == ST_POPPED &&
                 out_o.out_tag == $past(ent[0].tag) &&
                 out_o.out_priority == $past(ent[0].prio)))
    else $error("popped word does not match the head entry");

  // A successful push grows the fill level by exactly one.
  a_push_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |=> ($countones(vld) == $countones($past(vld)) + 1))
    else $error("push did not add exactly one entry");

  // A rejected item leaves the occupied slots of the chain unchanged.
  a_reject_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !cmd.push && !cmd.pop) |=> $stable(vld))
    else $error("rejected word changed the queue");

endmodule

`default_nettype wire

>>> hdl/spq_cell.sv
// One slot of the sorted shift chain: holds an entry and moves it on push or pop.
`default_nettype none

module spq_cell import spq_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire cmd_t   cmd_i,
  input  wire entry_t prev_i,
  input  wire logic   prev_ge_i,
  input  wire entry_t next_i,
  output entry_t      ent_o,
  output logic        ge_o
);

  logic              valid_q, valid_d;
  logic [PRIO_W-1:0] prio_q, prio_d;
  logic [TAG_W-1:0]  tag_q, tag_d;

  // The entry stays ahead of a new one when its priority is greater or equal.
  assign ge_o  = valid_q && ($signed(prio_q) >= $signed(cmd_i.prio));
  assign ent_o = '{valid: valid_q, prio: prio_q, tag: tag_q};

  always_comb begin
    valid_d = valid_q;
    prio_d  = prio_q;
    tag_d   = tag_q;
    if (cmd_i.pop) begin
      valid_d = next_i.valid;
      prio_d  = next_i.prio;
      tag_d   = next_i.tag;
    end else if (cmd_i.push && !ge_o) begin
      if (prev_ge_i) begin
        valid_d = 1'b1;
        prio_d  = cmd_i.prio;
        tag_d   = cmd_i.tag;
      end else begin
        valid_d = prev_i.valid;
        prio_d  = prev_i.prio;
        tag_d   = prev_i.tag;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q <= prio_d;
    tag_q  <= tag_d;
  end

endmodule

`default_nettype wire

>>> dv/stable_priority_queue_tb.sv
// Self-checking testbench for the stable priority queue: random pushes and pops against a predictor.
module stable_priority_queue_tb;
  import spq_pkg::*;

  // Stimulus size and run bounds.
  // The limit covers every word waiting out both idle draws and the long receiver stall.
  localparam int ITEMS      = 1850;
  localparam int LIMIT      = 100000;
  localparam int STALL_AT   = 1300;
  localparam int STALL_LEN  = 64;
  localparam int IDLE_PCT   = 6;
  localparam int TAIL       = 8;

  // One input word as the driver offers it.
  typedef struct {
    logic                     op;
    logic signed [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]         tag;
  } in_word_t;

  // One result word as the queue should return it.
  typedef struct {
    status_e                  status;
    logic [TAG_W-1:0]         tag;
    logic signed [PRIO_W-1:0] prio;
  } outcome_t;

  logic clk;
  logic rst_n;

  spq_in_if  in_ch ();
  spq_out_if out_ch ();

  stable_priority_queue dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  in_word_t word_plan_q[$];   // words still to be offered
  outcome_t outcome_q[$];     // results owed by the queue, oldest first

  // Predictor copy of the queue contents. Slot 0 is the next entry to leave.
  logic signed [PRIO_W-1:0] model_prio [CAPACITY];
  logic [TAG_W-1:0]         model_tag  [CAPACITY];
  int                       model_fill;

  int       mismatches;
  int       cycle_cnt;
  int       stall_left;
  int       words_taken;
  bit       offering;
  in_word_t offer_w;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  // Works out the result that one accepted word must produce and advances
  // the predictor. A new entry goes behind every entry whose priority is
  // greater or equal, so equal priorities leave in arrival order.
  task automatic predict_outcome(input in_word_t w);
    outcome_t r;
    int pos;
    r.status = ST_PUSHED;
    r.tag    = '0;
    r.prio   = '0;
    if (w.op == OP_POP) begin
      if (model_fill == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.status = ST_POPPED;
        r.tag    = model_tag[0];
        r.prio   = model_prio[0];
        for (int i = 0; i + 1 < model_fill; i++) begin
          model_prio[i] = model_prio[i+1];
          model_tag[i]  = model_tag[i+1];
        end
        model_fill--;
      end
    end else if (model_fill >= CAPACITY) begin
      // A push on a full queue is dropped and leaves the contents alone.
      r.status = ST_FULL;
    end else begin
      pos = 0;
      while (pos < model_fill && model_prio[pos] >= w.prio) pos++;
      for (int i = model_fill; i > pos; i--) begin
        model_prio[i] = model_prio[i-1];
        model_tag[i]  = model_tag[i-1];
      end
      model_prio[pos] = w.prio;
      model_tag[pos]  = w.tag;
      model_fill++;
    end
    outcome_q.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("[%0t] mismatch in %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  function automatic void plan_word(input logic op, input logic signed [PRIO_W-1:0] prio,
                                    input logic [TAG_W-1:0] tag);
    in_word_t w;
    w.op   = op;
    w.prio = prio;
    w.tag  = tag;
    word_plan_q.push_back(w);
  endfunction

  // Priority styles: a handful of values so that ties are common, the full
  // 16-bit range, or the extremes and the values around zero.
  function automatic logic signed [PRIO_W-1:0] pick_priority(input int mode);
    logic signed [PRIO_W-1:0] p;
    case (mode)
      0: p = PRIO_W'(int'($urandom_range(0, 3)) - 2);
      1: p = PRIO_W'($urandom);
      default: begin
        case ($urandom_range(0, 3))
          0: p = 16'sh7FFF;
          1: p = 16'sh8000;
          2: p = '0;
          default: p = '1;
        endcase
      end
    endcase
    return p;
  endfunction

  // Driver. The valid stays high until the word is taken; a new word is
  // picked only once the previous one has gone. Each input gets one
  // nonblocking assignment per edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_outcome(offer_w);
        offering = 1'b0;
      end
      if (!offering && word_plan_q.size() != 0 &&
          ((words_taken >= 700 && words_taken < 1000) || $urandom_range(0, 99) >= IDLE_PCT)) begin
        offer_w = word_plan_q.pop_front();
        offering = 1'b1;
        words_taken++;
      end
      in_ch.valid        <= offering;
      in_ch.operation    <= offer_w.op;
      in_ch.priority_req <= offer_w.prio;
      in_ch.tag          <= offer_w.tag;
    end
  end

  // Long receiver hold-off. With the output blocked the queue soon stops
  // taking words while the driver keeps offering.
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left <= 0;
    end else if (cycle_cnt == STALL_AT) begin
      stall_left <= STALL_LEN;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // Monitor. It checks each accepted result word against the oldest
  // expectation, field by field, and draws the next ready.
  always @(posedge clk) begin : result_check
    outcome_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("result word with nothing expected", 32'(out_ch.status), '0);
        end else begin
          want = outcome_q.pop_front();
          if (out_ch.status !== want.status)
            report_mismatch("status", 32'(out_ch.status), 32'(want.status));
          if (out_ch.out_tag !== want.tag)
            report_mismatch("out_tag", 32'(out_ch.out_tag), 32'(want.tag));
          if (out_ch.out_priority !== want.prio)
            report_mismatch("out_priority", 32'(out_ch.out_priority), 32'(want.prio));
        end
      end
      out_ch.ready <= (stall_left == 0) &&
                      ((cycle_cnt >= 400 && cycle_cnt < 800) ||
                       $urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  initial begin
    while (cycle_cnt < LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    int mode;
    int len;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.operation    = OP_PUSH;
    in_ch.priority_req = '0;
    in_ch.tag          = '0;
    out_ch.ready       = 1'b0;
    cycle_cnt          = 0;
    mismatches         = 0;
    model_fill         = 0;
    words_taken        = 0;
    offering           = 1'b0;
    offer_w            = '{OP_PUSH, '0, '0};

    // Directed words. A pop on the empty queue comes first. Then come pushes
    // with the extreme priorities and tags and several runs of equal
    // priority. They fill the queue, one more push hits a full queue, and
    // pops drain part of it.
    plan_word(OP_POP, 16'sh1234, 16'hABCD);
    plan_word(OP_PUSH, 16'sh7FFF, 16'h0000);
    plan_word(OP_PUSH, 16'sh8000, 16'hFFFF);
    plan_word(OP_PUSH, 16'sh0000, 16'h0001);
    plan_word(OP_PUSH, 16'sh0000, 16'h0002);
    plan_word(OP_PUSH, -16'sd1,   16'h0003);
    plan_word(OP_PUSH, 16'sh0001, 16'h0004);
    plan_word(OP_PUSH, 16'sh0000, 16'h0005);
    plan_word(OP_PUSH, 16'sh7FFF, 16'h0006);
    plan_word(OP_PUSH, 16'sh8000, 16'h0007);
    for (int i = 0; i < CAPACITY - 9; i++)
      plan_word(OP_PUSH, pick_priority(1), TAG_W'($urandom));
    plan_word(OP_PUSH, 16'sh7FFF, 16'h5A5A);
    for (int i = 0; i < 8; i++)
      plan_word(OP_POP, pick_priority(1), TAG_W'($urandom));

    // Random part in bursts. Push bursts longer than the capacity run into
    // a full queue, and pop bursts run it dry. Mixed bursts stir the order.
    while (word_plan_q.size() < ITEMS) begin
      mode = $urandom_range(0, 2);
      len  = $urandom_range(1, CAPACITY + 4);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          repeat (len) plan_word(OP_PUSH, pick_priority(mode), TAG_W'($urandom));
        end
        4, 5, 6, 7: begin
          repeat (len) plan_word(OP_POP, pick_priority(1), TAG_W'($urandom));
        end
        default: begin
          repeat (len) plan_word(1'($urandom_range(0, 1)), pick_priority(mode),
                                 TAG_W'($urandom));
        end
      endcase
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until every word has gone in and every result has come back.
    // Then wait out the TAIL window so that any stray result shows.
    while (word_plan_q.size() != 0 || offering || outcome_q.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
